>>> hw/rtl/http_chunked_body_decoder_assert.svh
// assertion macros shared by the checker
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define HCBD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("hcbd assertion failed");

// next-cycle implication, off during reset
`define HCBD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hcbd assertion failed");

// next-cycle implication that also holds across reset
`define HCBD_ASSERT_ALWAYS_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("hcbd assertion failed");

`endif

>>> hw/rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
package hcbd_pkg;

  // default width of the chunk size register
  localparam int SIZE_BITS_DEF = 32;
  // width of the decoded length counter, fixed by the result item
  localparam int LEN_BITS = 24;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_SIZE_LF  = 3'd1,
    PH_DATA     = 3'd2,
    PH_TRAIL_CR = 3'd3,
    PH_TRAIL_LF = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                out_valid;
    logic                body_done;
    logic [LEN_BITS-1:0] decoded_length;
  } res_t;

  // decoder state apart from the size register
  typedef struct packed {
    phase_t              phase;
    logic                digit_seen;
    logic [LEN_BITS-1:0] emitted_total;
  } ctl_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b >= CH_0 && b <= CH_9) begin
      d = b - CH_0;
      return {1'b1, d[3:0]};
    end else if (b >= CH_LO_A && b <= CH_LO_F) begin
      d = b - CH_LO_A;
      return {1'b1, d[3:0] + HEX_TEN};
    end else if (b >= CH_UP_A && b <= CH_UP_F) begin
      d = b - CH_UP_A;
      return {1'b1, d[3:0] + HEX_TEN};
    end
    return 5'd0;
  endfunction

endpackage

>>> hw/rtl/hcbd_step.sv
`timescale 1ns / 1ps
module hcbd_step #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  hcbd_pkg::in_t          item,
  input  hcbd_pkg::ctl_t         ctl,
  input  logic [SIZE_BITS-1:0]   chunk_count,
  output hcbd_pkg::ctl_t         ctl_next,
  output logic [SIZE_BITS-1:0]   chunk_count_next,
  output hcbd_pkg::res_t         res
);

  logic                       consumed;
  logic                       closed;
  logic                       valid;
  logic                       done;
  logic [4:0]                 hex;
  logic [SIZE_BITS-1:0]       cnt_dec;
  hcbd_pkg::phase_t           ph;
  logic [SIZE_BITS-1:0]       cnt;
  logic                       dig;
  logic [hcbd_pkg::LEN_BITS-1:0] tot;

  assign hex = hcbd_pkg::hex_decode(item.in_byte);

  // one byte through the phase machine
  always_comb begin
    consumed = 1'b0;
    closed   = 1'b0;
    valid    = 1'b0;
    done     = 1'b0;
    ph       = ctl.phase;
    cnt      = chunk_count;
    dig      = ctl.digit_seen;
    tot      = ctl.emitted_total;
    cnt_dec  = chunk_count - SIZE_BITS'(1);

    // optional line ends ahead of the byte's real phase
    unique case (ctl.phase)
      hcbd_pkg::PH_SIZE, hcbd_pkg::PH_DATA: begin
      end
      hcbd_pkg::PH_TRAIL_CR: begin
        if (item.in_byte == hcbd_pkg::CH_CR) begin
          consumed = 1'b1;
          ph       = hcbd_pkg::PH_TRAIL_LF;
        end else begin
          consumed = (item.in_byte == hcbd_pkg::CH_LF);
          ph       = hcbd_pkg::PH_SIZE;
          cnt      = '0;
          dig      = 1'b0;
        end
      end
      hcbd_pkg::PH_TRAIL_LF: begin
        consumed = (item.in_byte == hcbd_pkg::CH_LF);
        ph       = hcbd_pkg::PH_SIZE;
        cnt      = '0;
        dig      = 1'b0;
      end
      hcbd_pkg::PH_SIZE_LF: begin
        consumed = (item.in_byte == hcbd_pkg::CH_LF);
        ph       = hcbd_pkg::PH_DATA;
      end
      default: begin
        closed = 1'b1;
      end
    endcase

    // size line digits or payload byte
    if (!consumed && !closed) begin
      if (ph == hcbd_pkg::PH_SIZE) begin
        if (item.in_byte == hcbd_pkg::CH_CR) begin
          if (!dig || cnt == '0) begin
            done = 1'b1;
          end else begin
            ph = hcbd_pkg::PH_SIZE_LF;
          end
        end else if (hex[4]) begin
          cnt = {cnt[SIZE_BITS-5:0], hex[3:0]};
          dig = 1'b1;
        end
      end else if (ph == hcbd_pkg::PH_DATA) begin
        valid = 1'b1;
        if (tot != '1) begin
          tot = tot + 1'b1;
        end
        cnt = cnt_dec;
        if (cnt_dec == '0) begin
          ph = hcbd_pkg::PH_TRAIL_CR;
        end
      end
    end

    // buffer end closes the body
    if (!closed && item.end_of_buffer) begin
      done = 1'b1;
    end
    if (done) begin
      ph = hcbd_pkg::PH_DONE;
    end

    ctl_next.phase         = ph;
    ctl_next.digit_seen    = dig;
    ctl_next.emitted_total = tot;
    chunk_count_next       = cnt;

    res.out_byte       = valid ? item.in_byte : 8'd0;
    res.out_valid      = valid;
    res.body_done      = done;
    res.decoded_length = tot;
  end

endmodule

>>> hw/rtl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// channel  ports                          item type         moves when
// input    in_valid, in_stall, in_item    hcbd_pkg::in_t    in_valid && !in_stall
// result   res_valid, res_stall, res      hcbd_pkg::res_t   res_valid && !res_stall
//
// one byte per cycle sustained while res_stall is low; a taken byte goes into the input
// register, then through the phase logic into the result register, where it is shown
// the phase logic is a single step from the input register to the result register
// rst (synchronous) returns to the size line with a zero length and empties both registers
// res_stall holds the result register; the input register takes one more byte, then
// in_stall rises until the result moves
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcbd_pkg::in_t  in_item,
  output logic           res_valid,
  input  logic           res_stall,
  output hcbd_pkg::res_t res
);

  logic                 in_full;
  logic                 in_full_next;
  hcbd_pkg::in_t        in_q;
  logic                 res_full;
  logic                 res_full_next;
  hcbd_pkg::res_t       res_q;
  logic                 advance;
  logic                 take;
  hcbd_pkg::ctl_t       ctl;
  hcbd_pkg::ctl_t       ctl_next;
  logic [SIZE_BITS-1:0] chunk_count;
  logic [SIZE_BITS-1:0] chunk_count_next;
  hcbd_pkg::res_t       step_res;

  // pipeline handshake
  assign advance   = in_full && (!res_full || !res_stall);
  assign in_stall  = in_full && !advance;
  assign take      = in_valid && !in_stall;
  assign res_valid = res_full;
  assign res       = res_q;

  always_comb begin
    in_full_next  = take ? 1'b1 : (advance ? 1'b0 : in_full);
    res_full_next = advance ? 1'b1 : (res_stall ? res_full : 1'b0);
  end

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .item             (in_q),
    .ctl              (ctl),
    .chunk_count      (chunk_count),
    .ctl_next         (ctl_next),
    .chunk_count_next (chunk_count_next),
    .res              (step_res)
  );

  // control and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full                <= 1'b0;
      res_full               <= 1'b0;
      ctl.phase              <= hcbd_pkg::PH_SIZE;
      ctl.digit_seen         <= 1'b0;
      ctl.emitted_total      <= '0;
      chunk_count            <= '0;
    end else begin
      in_full  <= in_full_next;
      res_full <= res_full_next;
      if (advance) begin
        ctl         <= ctl_next;
        chunk_count <= chunk_count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= in_item;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

endmodule

>>> hw/rtl/hcbd_checker.sv
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_assert.svh"
module hcbd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input hcbd_pkg::in_t  in_item,
  input logic           res_valid,
  input logic           res_stall,
  input hcbd_pkg::res_t res
);

  // a stalled input item stays put
  `HCBD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))

  // a stalled result stays put
  `HCBD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

  // no payload byte shown without its valid flag
  `HCBD_ASSERT_NOW(a_byte_zero, res_valid && !res.out_valid, res.out_byte == 8'd0)

  // a shown payload byte comes with a nonzero decoded length
  `HCBD_ASSERT_NOW(a_len_counted, res_valid && res.out_valid, res.decoded_length != '0)

  // reset empties the pipeline
  `HCBD_ASSERT_ALWAYS_NEXT(a_rst_empty, rst, !res_valid && !in_stall)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

>>> sim/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int SIZE_W = SIZE_BITS_DEF;
  localparam int MODE_LEN = 180;
  localparam int PAUSE_STEP = 700;
  localparam int RAND_BYTES = 1450;
  localparam int DRAIN_CYCLES = 20;

  // idle pattern, stepped through as bytes go in
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // what follows a data run
  typedef enum int unsigned {
    TR_CRLF,
    TR_CR,
    TR_LF,
    TR_NONE
  } trail_t;

  // how the body is closed at the end of the run
  typedef enum int unsigned {
    END_ZERO,
    END_NO_DIGIT,
    END_WRAP_ZERO,
    END_BUFFER
  } body_end_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  in_t byte_queue[$];
  res_t expected_res[$];
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_err = 0;
  int unsigned next_pause = 600;

  // decoder state as predicted
  phase_t ph_q = PH_SIZE;
  logic [SIZE_W-1:0] size_q = '0;
  logic seen_q = 1'b0;
  logic [LEN_BITS-1:0] total_q = '0;

  http_chunked_body_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic idle_mode_t mode_of(input int unsigned n);
    return idle_mode_t'((n / MODE_LEN) % 4);
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_F) ||
           (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  // one step of the decoder, updates the predicted state
  function automatic res_t decode_byte(input in_t it);
    res_t r;
    logic [7:0] b;
    logic eaten;
    logic emit;
    logic close;
    r = '0;
    b = it.in_byte;
    eaten = 1'b0;
    emit = 1'b0;
    close = 1'b0;
    if (ph_q > PH_TRAIL_LF) begin
      r.decoded_length = total_q;
      return r;
    end
    // optional cr, then optional lf after data
    if (ph_q == PH_TRAIL_CR) begin
      eaten = (b == CH_CR);
      ph_q = PH_TRAIL_LF;
    end
    if (ph_q == PH_TRAIL_LF && !eaten) begin
      eaten = (b == CH_LF);
      ph_q = PH_SIZE;
      size_q = '0;
      seen_q = 1'b0;
    end
    // optional lf after the size line
    if (ph_q == PH_SIZE_LF) begin
      eaten = (b == CH_LF);
      ph_q = PH_DATA;
    end
    if (!eaten) begin
      if (ph_q == PH_SIZE) begin
        if (b == CH_CR) begin
          if (!seen_q || size_q == '0) close = 1'b1;
          else ph_q = PH_SIZE_LF;
        end else if (is_hex_char(b)) begin
          // letters have low nibble 1..6 for both cases
          size_q = {size_q[SIZE_W-5:0], (b <= CH_9) ? b[3:0] : b[3:0] + HEX_TEN - 4'd1};
          seen_q = 1'b1;
        end
      end else if (ph_q == PH_DATA) begin
        emit = 1'b1;
        if (total_q != '1) total_q = total_q + 1'b1;
        size_q = size_q - 1'b1;
        if (size_q == '0) ph_q = PH_TRAIL_CR;
      end
    end
    if (it.end_of_buffer) close = 1'b1;
    if (close) ph_q = PH_DONE;
    r.out_byte = emit ? it.in_byte : 8'h00;
    r.out_valid = emit;
    r.body_done = close;
    r.decoded_length = total_q;
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eob);
    in_t it;
    it.in_byte = b;
    it.end_of_buffer = eob;
    byte_queue.push_back(it);
  endtask

  // any byte that the size line ignores
  function automatic logic [7:0] junk_char(input logic allow_lf);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_hex_char(c) || c == CH_CR || (!allow_lf && c == CH_LF))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // size line, payload and trailer of one chunk; eob_at marks a payload byte
  task automatic add_chunk(input int unsigned len, input logic wrap, input logic with_lf,
                           input trail_t trail, input int eob_at);
    logic [3:0] digs[$];
    logic [31:0] v;
    logic [7:0] c;
    int nd;
    v = len;
    nd = 1;
    while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
    nd = nd + $urandom_range(0, 2);
    // extra digits up front fall off the top of the size register
    if (wrap) begin
      repeat ($urandom_range(1, 3)) digs.push_back(4'($urandom_range(0, 15)));
      nd = 8;
    end
    if (nd > 8) nd = 8;
    for (int i = nd - 1; i >= 0; i--) digs.push_back(v[4*i +: 4]);
    foreach (digs[i]) begin
      if ($urandom_range(0, 7) == 0) add_byte(junk_char(i != 0), 1'b0);
      if (digs[i] < HEX_TEN) c = CH_0 + digs[i];
      else c = ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + (digs[i] - HEX_TEN);
      add_byte(c, 1'b0);
    end
    repeat ($urandom_range(0, 2)) add_byte(junk_char(1'b1), 1'b0);
    add_byte(CH_CR, 1'b0);
    if (with_lf) add_byte(CH_LF, 1'b0);
    // payload; a missing lf must not be made up by the first byte
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      while (i == 0 && !with_lf && c == CH_LF) c = 8'($urandom_range(0, 255));
      add_byte(c, i == eob_at);
    end
    case (trail)
      TR_CRLF: begin
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
      end
      TR_CR: add_byte(CH_CR, 1'b0);
      TR_LF: add_byte(CH_LF, 1'b0);
      default: ;
    endcase
  endtask

  // driver: offers the next byte when the input slot is free, unless idling or held at a pause
  always @(posedge clk) begin : drive
    int unsigned cnt;
    logic go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      cnt = n_sent;
      if (in_valid && !in_stall) begin
        expected_res.push_back(decode_byte(in_item));
        cnt = cnt + 1;
        n_sent <= cnt;
      end
      if (!in_valid || !in_stall) begin
        go = (byte_queue.size() != 0);
        // hold off at a pause point until every result is back
        if (cnt == next_pause) begin
          if (n_got == cnt) next_pause <= next_pause + PAUSE_STEP;
          else go = 1'b0;
        end
        case (mode_of(cnt))
          IDLE_SENDER: if ($urandom_range(0, 99) < 70) go = 1'b0;
          IDLE_BOTH: if ($urandom_range(0, 99) < 36) go = 1'b0;
          default: ;
        endcase
        in_valid <= go;
        if (go) in_item <= byte_queue.pop_front();
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        n_got <= n_got + 1;
        if (expected_res.size() == 0) begin
          $error("result with no byte pending: %h", res);
          n_err++;
        end else begin
          want = expected_res.pop_front();
          if (res.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, res.out_byte);
            n_err++;
          end
          if (res.out_valid !== want.out_valid) begin
            $error("out_valid: expected %b, got %b", want.out_valid, res.out_valid);
            n_err++;
          end
          if (res.body_done !== want.body_done) begin
            $error("body_done: expected %b, got %b", want.body_done, res.body_done);
            n_err++;
          end
          if (res.decoded_length !== want.decoded_length) begin
            $error("decoded_length: expected %0d, got %0d", want.decoded_length,
                   res.decoded_length);
            n_err++;
          end
        end
      end
      case (mode_of(n_sent))
        IDLE_RECEIVER: res_stall <= ($urandom_range(0, 99) < 70);
        IDLE_BOTH: res_stall <= ($urandom_range(0, 99) < 36);
        default: res_stall <= 1'b0;
      endcase
    end
  end

  initial begin : stim
    int unsigned base;
    int unsigned len;
    body_end_t how;
    // wrapped size with every letter bound, junk, no lf, no trailer
    add_byte(CH_LO_A, 1'b0);
    add_byte(CH_UP_F, 1'b0);
    add_byte(CH_LO_F, 1'b0);
    add_byte(CH_UP_A, 1'b0);
    add_byte(CH_9, 1'b0);
    repeat (7) add_byte(CH_0, 1'b0);
    add_byte(CH_0 + 8'd2, 1'b0);
    add_byte(8'h3b, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(CH_LF, 1'b0);
    // one byte of zero, cr only after it
    add_byte(CH_0 + 8'd1, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(CH_CR, 1'b0);
    // payload that starts with a line end, lf only after it
    add_byte(CH_0 + 8'd2, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(CH_LF, 1'b0);

    // random chunks, mostly short, sometimes malformed but still open
    base = byte_queue.size();
    while (byte_queue.size() < base + RAND_BYTES) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 16);
      add_chunk(len, $urandom_range(0, 5) == 0, $urandom_range(0, 7) != 0,
                $urandom_range(0, 1) ? TR_CRLF : trail_t'($urandom_range(0, 3)), -1);
    end

    // close the body one way, then bytes that must be ignored
    how = body_end_t'($urandom_range(0, 3));
    case (how)
      END_ZERO: begin
        repeat ($urandom_range(1, 4)) add_byte(CH_0, 1'b0);
        add_byte(CH_CR, 1'($urandom_range(0, 1)));
      end
      END_NO_DIGIT: begin
        repeat ($urandom_range(0, 3)) add_byte(junk_char(1'b1), 1'b0);
        add_byte(CH_CR, 1'($urandom_range(0, 1)));
      end
      END_WRAP_ZERO: begin
        add_byte(CH_0 + 8'd1, 1'b0);
        repeat (8) add_byte(CH_0, 1'b0);
        add_byte(CH_CR, 1'($urandom_range(0, 1)));
      end
      default: add_chunk(6, 1'b0, 1'b1, TR_CRLF, 2);
    endcase
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (9) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (byte_queue.size() != 0 || in_valid || n_got != n_sent);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_res.size() != 0) begin
      $error("%0d results never arrived", expected_res.size());
      n_err++;
    end
    if (n_err == 0) $display("[http_chunked_body_decoder] OK");
    else $display("[http_chunked_body_decoder] ERROR");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[http_chunked_body_decoder] ERROR");
    $finish;
  end

endmodule
